[rtl/nhpw_pkg.sv]
// Shared types and constants of the next-hop path walker.
// No dependencies; used by every module of the block.
package nhpw_pkg;

	localparam int PT_W     = 8;
	localparam int SLOT_W   = 3;
	localparam int CNT_W    = 4;
	localparam int DIST_W   = 24;
	localparam int POS_W    = 24;
	localparam int HOP_W    = 6;
	localparam int HOPC_W   = 5;
	localparam int IN_W     = 120;
	localparam int OUT_W    = 80;

	localparam logic [CNT_W-1:0]  MaxNb       = 4'd8;
	localparam logic [HOP_W-1:0]  MaxHops     = 6'd20;
	localparam logic [HOP_W-1:0]  HopLimitRst = 6'd20;
	localparam logic [DIST_W-1:0] DistOnes    = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		OP_POS   = 2'd0,
		OP_NBR   = 2'd1,
		OP_DIST  = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNREACH   = 2'd1,
		ST_DEAD_END  = 2'd2,
		ST_HOP_LIMIT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QWAIT,
		S_QCHK,
		S_HCHK,
		S_SCAN,
		S_DRAIN1,
		S_DRAIN2,
		S_STEP,
		S_PWAIT,
		S_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic                load;
		logic                query;
		logic                issue;
		logic                first;
		logic [SLOT_W-1:0]   slot;
		logic                step;
		logic                emit;
		logic                emit_ok;
		status_t             emit_status;
		logic                emit_last;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic                at_target;
		logic                unreach;
		logic [CNT_W-1:0]    cnt;
		logic                out_free;
	} sts_t;

endpackage

[rtl/nhpw_datapath.sv]
// Datapath of the path walker: graph stores, neighbour scan pipeline, output word.
// Depends on nhpw_pkg; driven by commands from nhpw_ctrl.
module nhpw_datapath import nhpw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  opcode_t            opcode,
	input  logic [IN_W-1:0]    in_data,
	output sts_t               sts,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	logic [PT_W-1:0]   pt_a, pt_b;
	logic [SLOT_W-1:0] slot_in;
	logic [CNT_W-1:0]  cnt_in, cnt_sat;
	logic [DIST_W-1:0] dist_in;
	logic [3*POS_W-1:0] pos_in;

	assign pt_a    = in_data[7:0];
	assign pt_b    = in_data[15:8];
	assign slot_in = in_data[18:16];
	assign cnt_in  = in_data[22:19];
	assign dist_in = in_data[46:23];
	assign pos_in  = in_data[118:47];
	assign cnt_sat = (cnt_in > MaxNb) ? MaxNb : cnt_in;

	logic [3*POS_W-1:0]     pos_mem [256];
	logic [PT_W-1:0]        nb_mem [2048];
	logic [DIST_W-1:0]      edge_mem [2048];
	logic [CNT_W-1:0]       cnt_mem [256];
	logic [DIST_W-1:0]      dist_mem [65536];
	logic [255:0]           cnt_vld_q;

	logic [PT_W-1:0]        cur_q, tgt_q;
	logic [3*POS_W-1:0]     pos_rd_q;
	logic [CNT_W-1:0]       cnt_rd_q;
	logic                   cnt_vld_rd_q;
	logic [DIST_W-1:0]      dist_rd_q;
	logic [PT_W-1:0]        nb_s1, nb_s2;
	logic [DIST_W-1:0]      edge_s1, edge_s2;
	logic                   v_s1, v_s2, first_s1, first_s2;
	logic [PT_W-1:0]        best_q;
	logic [DIST_W-1:0]      best_d_q;
	logic [PT_W-1:0]        row;
	logic [DIST_W:0]        sum;
	logic [DIST_W-1:0]      cand;
	logic                   out_vld_q;
	logic [OUT_W-1:0]       out_data_q;
	logic [1:0]             out_user_q;
	logic                   out_last_q;

	// Position store: write on load, read at the current point
	always_ff @(posedge clk) begin
		if (cmd.load && opcode == OP_POS)
			pos_mem[pt_a] <= pos_in;
		pos_rd_q <= pos_mem[cur_q];
	end

	// Neighbour lists: read one slot per issue
	always_ff @(posedge clk) begin
		if (cmd.load && opcode == OP_NBR) begin
			nb_mem[{pt_a, slot_in}]   <= pt_b;
			edge_mem[{pt_a, slot_in}] <= dist_in;
		end
		nb_s1   <= nb_mem[{cur_q, cmd.slot}];
		edge_s1 <= edge_mem[{cur_q, cmd.slot}];
		nb_s2   <= nb_s1;
		edge_s2 <= edge_s1;
	end

	// Neighbour counts: memory plus per-entry valid bits
	always_ff @(posedge clk) begin
		if (cmd.load && opcode == OP_NBR)
			cnt_mem[pt_a] <= cnt_sat;
		cnt_rd_q <= cnt_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.load && opcode == OP_NBR)
				cnt_vld_q[pt_a] <= 1'b1;
			cnt_vld_rd_q <= cnt_vld_q[cur_q];
		end
	end

	// Distance table: row is the scanned neighbour, else the current point
	assign row = v_s1 ? nb_s1 : cur_q;

	always_ff @(posedge clk) begin
		if (cmd.load && opcode == OP_DIST)
			dist_mem[{pt_a, pt_b}] <= dist_in;
		dist_rd_q <= dist_mem[{row, tgt_q}];
	end

	// Scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			first_s1 <= cmd.first;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
		end
	end

	// Saturating cost and first strict minimum
	assign sum  = {1'b0, edge_s2} + {1'b0, dist_rd_q};
	assign cand = sum[DIST_W] ? DistOnes : sum[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (v_s2 && (first_s2 || cand < best_d_q)) begin
			best_q   <= nb_s2;
			best_d_q <= cand;
		end
	end

	// Current and target point
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			cur_q <= pt_a;
			tgt_q <= pt_b;
		end else if (cmd.step) begin
			cur_q <= best_q;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.emit)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= cmd.emit_ok ? {pos_rd_q, cur_q} : '0;
			out_user_q <= cmd.emit_status;
			out_last_q <= cmd.emit_last;
		end
	end

	assign sts.at_target = (cur_q == tgt_q);
	assign sts.unreach   = (dist_rd_q == DistOnes);
	assign sts.cnt       = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign sts.out_free  = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

[rtl/nhpw_ctrl.sv]
// Controller of the path walker: query sequencing, hop count and neighbour scan.
// Depends on nhpw_pkg; issues commands to nhpw_datapath.
module nhpw_ctrl import nhpw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HOP_W-1:0] cfg_wdata,
	input  logic             in_acc,
	input  opcode_t          opcode,
	input  sts_t             sts,
	output logic             ready,
	output cmd_t             cmd
);

	state_t              state_q, state_d;
	logic [HOP_W-1:0]    hop_limit_q, limit;
	logic [HOPC_W-1:0]   hop_q;
	logic [CNT_W-1:0]    idx_q;
	logic                hop_hit;

	assign limit   = (hop_limit_q > MaxHops) ? MaxHops : hop_limit_q;
	assign hop_hit = ({1'b0, hop_q} == limit);

	// Hop limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hop_limit_q <= HopLimitRst;
		else if (cfg_we)
			hop_limit_q <= cfg_wdata;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_acc && opcode == OP_QUERY) state_d = S_QWAIT;
			S_QWAIT:  state_d = S_QCHK;
			S_QCHK:   if (sts.out_free)
				state_d = (sts.at_target || sts.unreach) ? S_IDLE : S_HCHK;
			S_HCHK: begin
				if (hop_hit || sts.cnt == '0) begin
					if (sts.out_free)
						state_d = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN:   if (idx_q == sts.cnt - 1'b1) state_d = S_DRAIN1;
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: state_d = S_STEP;
			S_STEP:   state_d = S_PWAIT;
			S_PWAIT:  state_d = S_EMIT;
			S_EMIT:   if (sts.out_free) state_d = sts.at_target ? S_IDLE : S_HCHK;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd             = '0;
		cmd.emit_status = ST_OK;
		cmd.slot        = idx_q[SLOT_W-1:0];
		ready           = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load  = in_acc && opcode != OP_QUERY;
				cmd.query = in_acc && opcode == OP_QUERY;
			end
			S_QCHK: begin
				cmd.emit = sts.out_free;
				if (sts.at_target) begin
					cmd.emit_ok   = 1'b1;
					cmd.emit_last = 1'b1;
				end else if (sts.unreach) begin
					cmd.emit_status = ST_UNREACH;
					cmd.emit_last   = 1'b1;
				end else begin
					cmd.emit_ok = 1'b1;
				end
			end
			S_HCHK: begin
				cmd.emit_last = 1'b1;
				if (hop_hit) begin
					cmd.emit        = sts.out_free;
					cmd.emit_status = ST_HOP_LIMIT;
				end else if (sts.cnt == '0) begin
					cmd.emit        = sts.out_free;
					cmd.emit_status = ST_DEAD_END;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				cmd.first = (idx_q == '0);
			end
			S_STEP:   cmd.step = 1'b1;
			S_EMIT: begin
				cmd.emit      = sts.out_free;
				cmd.emit_ok   = 1'b1;
				cmd.emit_last = sts.at_target;
			end
			default: ;
		endcase
	end

	// State, hop and slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hop_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_QCHK)
				hop_q <= '0;
			else if (state_q == S_STEP)
				hop_q <= hop_q + 1'b1;
			if (state_q == S_SCAN)
				idx_q <= idx_q + 1'b1;
			else
				idx_q <= '0;
		end
	end

endmodule

[rtl/next_hop_path_walker_unit.sv]
// Greedy next-hop path walker: waypoint graph stores and query walk.
// Accepts one word at a time while idle; a query occupies the block until its last
// result is registered for output. Per hop the scan makes one distance-table read
// per neighbour, pipelined. Asynchronous active-low reset clears control state and
// the neighbour-count valid bits and sets hop_limit to 20; other stores are unset.
module next_hop_path_walker_unit import nhpw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HOP_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// point_a, point_b, slot, neighbour_count, distance, pos_x, pos_y, pos_z, pad
	input  logic [IN_W-1:0]  s_tdata,
	// opcode
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// point_index, out_x, out_y, out_z
	output logic [OUT_W-1:0] m_tdata,
	// status
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	cmd_t    cmd;
	sts_t    sts;
	opcode_t opcode;
	logic    in_acc;

	assign opcode = opcode_t'(s_tuser);
	assign in_acc = s_tvalid && s_tready;

	nhpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_acc   (in_acc),
		.opcode   (opcode),
		.sts      (sts),
		.ready    (s_tready),
		.cmd      (cmd)
	);

	nhpw_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.opcode  (opcode),
		.in_data (s_tdata),
		.sts     (sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// A failure word is always the last and carries no point
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
		else $error("failure word not last or not zero");

	// A query holds off further input words
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
		else $error("input accepted during query");

endmodule
